[design/ttip_pkg.sv]
// ----------------------------------------------------------------------------
// ttip_pkg
// Shared types, constants and helper functions of the text-to-integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ttip_pkg;

  // Default width of the byte position counter.
  localparam int OFFSET_BITS_DEF = 16;

  // Field widths.
  localparam int VALUE_W      = 64;
  localparam int END_W        = 16;
  localparam int RADIX_W      = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_SEL   = 2'd2;

  // Reset values of the registers.
  localparam logic [RADIX_W-1:0] RADIX_RST     = 5'd10;
  localparam logic               SIGNED_RST    = 1'b1;
  localparam logic [1:0]         WIDTH_SEL_RST = 2'd3;

  // Width select codes.
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  // Queue geometry, used by both internal queues.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_A_UP    = 8'h41;
  localparam logic [7:0] CH_F_UP    = 8'h46;
  localparam logic [7:0] CH_A_LOW   = 8'h61;
  localparam logic [7:0] CH_F_LOW   = 8'h66;
  localparam logic [7:0] CH_B_LOW   = 8'h62;
  localparam logic [7:0] CH_X_LOW   = 8'h78;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Input request and result payloads.
  typedef struct packed {
    logic [7:0] char_in;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [END_W-1:0]   end_offset;
    logic               end_valid;
  } result_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
    logic [1:0]         width_select;
  } cfg_t;

  // Classified byte, as queued between front and back.
  typedef struct packed {
    logic       last;
    logic       nul;
    logic       blank;
    logic       minus;
    logic       plus;
    logic       char0;
    logic       letter_x;
    logic       letter_b;
    logic       digit_ok;
    logic [3:0] digit;
  } class_t;

  // Front-to-back link: head of the byte queue.
  typedef struct packed {
    logic   valid;
    class_t cls;
  } byte_link_t;

  // Raw result before width cut and sign handling.
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               neg;
    logic [END_W-1:0]   end_offset;
    logic               end_valid;
  } raw_t;

  // Back-to-result-queue link.
  typedef struct packed {
    logic valid;
    raw_t data;
  } raw_link_t;

  // Classify one byte of text.
  function automatic class_t classify(logic [7:0] c, logic last);
    class_t     k;
    logic [7:0] lower;
    lower      = c | CASE_BIT;
    k.last     = last;
    k.nul      = (c == CH_NUL);
    k.blank    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    k.minus    = (c == CH_MINUS);
    k.plus     = (c == CH_PLUS);
    k.char0    = (c == CH_ZERO);
    k.letter_x = (lower == CH_X_LOW);
    k.letter_b = (lower == CH_B_LOW);
    k.digit_ok = 1'b1;
    k.digit    = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      k.digit = 4'(c - CH_ZERO);
    end else if (c >= CH_A_LOW && c <= CH_F_LOW) begin
      k.digit = 4'(c - CH_A_LOW + 8'd10);
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      k.digit = 4'(c - CH_A_UP + 8'd10);
    end else begin
      k.digit_ok = 1'b0;
    end
    return k;
  endfunction

  // Negate on minus, cut to the selected width, then sign or zero extend.
  function automatic logic [VALUE_W-1:0] finish_value(logic [VALUE_W-1:0] acc,
                                                      logic neg, logic sgn,
                                                      logic [1:0] wsel);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] mask;
    logic               top;
    v = (sgn && neg) ? (~acc + 64'd1) : acc;
    unique case (wsel)
      WSEL_8: begin
        mask = 64'h0000_0000_0000_00FF;
        top  = v[7];
      end
      WSEL_16: begin
        mask = 64'h0000_0000_0000_FFFF;
        top  = v[15];
      end
      WSEL_32: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        top  = v[31];
      end
      default: begin
        mask = 64'hFFFF_FFFF_FFFF_FFFF;
        top  = 1'b0;
      end
    endcase
    return (sgn && top) ? (v | ~mask) : (v & mask);
  endfunction

endpackage

`default_nettype wire

[design/ttip_front.sv]
// ----------------------------------------------------------------------------
// ttip_front
// Accepts text bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  ttip_pkg::item_t      item,
  output ttip_pkg::byte_link_t link,
  input  wire                  take
);

  ttip_pkg::class_t                    entries [ttip_pkg::Q_DEPTH];
  logic [ttip_pkg::Q_PTR_W-1:0]        wptr;
  logic [ttip_pkg::Q_PTR_W-1:0]        rptr;
  logic [ttip_pkg::Q_CNT_W-1:0]        count;
  logic                                wr_en;
  logic                                rd_en;

  assign full       = (count == ttip_pkg::Q_CNT_W'(ttip_pkg::Q_DEPTH));
  assign wr_en      = push && !full;
  assign rd_en      = take && link.valid;
  assign link.valid = (count != '0);
  assign link.cls   = entries[rptr];

  // Classified byte storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= ttip_pkg::classify(item.char_in, item.final_byte);
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/ttip_back.sv]
// ----------------------------------------------------------------------------
// ttip_back
// Parsing FSM and accumulator; one classified byte per cycle unless res_full.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_back #(
  parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ttip_pkg::cfg_t       cfg,
  input  ttip_pkg::byte_link_t link,
  output logic                 take,
  input  wire                  res_full,
  output ttip_pkg::raw_link_t  res
);

  localparam logic [2:0] PH_BLANK      = 3'd0;
  localparam logic [2:0] PH_AFTER_SIGN = 3'd1;
  localparam logic [2:0] PH_ZERO_AUTO  = 3'd2;
  localparam logic [2:0] PH_ZERO_FIXED = 3'd3;
  localparam logic [2:0] PH_DIGITS     = 3'd4;
  localparam logic [2:0] PH_DRAIN      = 3'd5;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [2:0]                        phase;
  logic [2:0]                        phase_next;
  logic [ttip_pkg::VALUE_W-1:0]      accumulator;
  logic [ttip_pkg::VALUE_W-1:0]      accumulator_next;
  logic [ttip_pkg::RADIX_W-1:0]      active_base;
  logic [ttip_pkg::RADIX_W-1:0]      active_base_next;
  logic                              minus_seen;
  logic                              minus_seen_next;
  logic [OFFSET_BITS-1:0]            position;
  logic [OFFSET_BITS-1:0]            position_next;

  ttip_pkg::class_t                  cls;
  logic [OFFSET_BITS-1:0]            pos_inc;
  logic [ttip_pkg::RADIX_W-1:0]      base_first;
  logic [ttip_pkg::RADIX_W-1:0]      base_sel;
  logic [ttip_pkg::VALUE_W-1:0]      acc_mul;
  logic                              digit_fits;
  logic                              do_first;
  logic                              do_prefix;
  logic                              do_step;
  logic                              allow_x;
  logic                              allow_b;
  logic                              restart;
  logic                              emit;
  logic                              emit_valid;
  logic [ttip_pkg::VALUE_W-1:0]      emit_acc;
  logic [OFFSET_BITS-1:0]            emit_pos;

  assign cls     = link.cls;
  assign take    = link.valid && !res_full;
  assign pos_inc = (position == POS_MAX) ? position : position + 1'b1;

  // Base chosen at the first byte after blanks and sign.
  assign base_first = (cfg.radix != '0) ? cfg.radix :
                      (cls.char0 ? ttip_pkg::RADIX_W'(8) : ttip_pkg::RADIX_W'(10));

  // Next-state logic for one byte.
  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    active_base_next = active_base;
    minus_seen_next  = minus_seen;
    position_next    = position;
    base_sel         = active_base;
    do_first         = 1'b0;
    do_prefix        = 1'b0;
    do_step          = 1'b0;
    allow_x          = 1'b0;
    allow_b          = 1'b0;
    restart          = 1'b0;
    emit             = 1'b0;
    emit_valid       = 1'b0;
    emit_acc         = '0;
    emit_pos         = '0;
    acc_mul          = '0;
    digit_fits       = 1'b0;

    // Phase dispatch.
    unique case (phase)
      PH_BLANK: begin
        priority if (position == '0 && cls.nul) begin
          emit    = 1'b1;
          restart = 1'b1;
        end else if (cls.blank) begin
          if (cls.last) begin
            emit    = 1'b1;
            restart = 1'b1;
          end else begin
            position_next = pos_inc;
          end
        end else if (cfg.signed_mode && (cls.minus || cls.plus)) begin
          minus_seen_next = cls.minus;
          if (cls.last) begin
            emit    = 1'b1;
            restart = 1'b1;
          end else begin
            phase_next    = PH_AFTER_SIGN;
            position_next = pos_inc;
          end
        end else begin
          do_first = 1'b1;
        end
      end
      PH_AFTER_SIGN: begin
        do_first = 1'b1;
      end
      PH_ZERO_AUTO: begin
        do_prefix = 1'b1;
        allow_x   = 1'b1;
        allow_b   = 1'b1;
      end
      PH_ZERO_FIXED: begin
        do_prefix = 1'b1;
        allow_x   = (active_base == ttip_pkg::RADIX_W'(16));
        allow_b   = (active_base == ttip_pkg::RADIX_W'(2));
      end
      PH_DIGITS: begin
        do_step = 1'b1;
      end
      default: begin
        // Draining the rest of a string after a non-digit.
        if (cls.nul || cls.last) begin
          restart = 1'b1;
        end
      end
    endcase

    // First significant byte: fix the base, hold a leading zero for a prefix.
    if (do_first) begin
      active_base_next = base_first;
      base_sel         = base_first;
      if (cls.char0 && !cls.last) begin
        phase_next    = (cfg.radix == '0) ? PH_ZERO_AUTO : PH_ZERO_FIXED;
        position_next = pos_inc;
      end else begin
        do_step = 1'b1;
      end
    end

    // Byte after a leading zero: a prefix letter only counts if more follows.
    if (do_prefix) begin
      priority if (!cls.last && cls.letter_x && allow_x) begin
        active_base_next = ttip_pkg::RADIX_W'(16);
        phase_next       = PH_DIGITS;
        position_next    = pos_inc;
      end else if (!cls.last && cls.letter_b && allow_b) begin
        active_base_next = ttip_pkg::RADIX_W'(2);
        phase_next       = PH_DIGITS;
        position_next    = pos_inc;
      end else begin
        do_step = 1'b1;
      end
    end

    // Digit accumulation with the base in force.
    if (do_step) begin
      digit_fits = cls.digit_ok && ({1'b0, cls.digit} < base_sel);
      acc_mul    = accumulator * ttip_pkg::VALUE_W'(base_sel)
                   + ttip_pkg::VALUE_W'(cls.digit);
      priority if (cls.nul) begin
        emit       = 1'b1;
        emit_valid = 1'b1;
        emit_acc   = accumulator;
        emit_pos   = position;
        restart    = 1'b1;
      end else if (!digit_fits) begin
        emit       = 1'b1;
        emit_valid = 1'b1;
        emit_acc   = accumulator;
        emit_pos   = position;
        if (cls.last) begin
          restart = 1'b1;
        end else begin
          phase_next = PH_DRAIN;
        end
      end else begin
        accumulator_next = acc_mul;
        if (cls.last) begin
          emit       = 1'b1;
          emit_valid = 1'b1;
          emit_acc   = acc_mul;
          emit_pos   = pos_inc;
          restart    = 1'b1;
        end else begin
          phase_next    = PH_DIGITS;
          position_next = pos_inc;
        end
      end
    end

    // A finished string leaves the state of a fresh one.
    if (restart) begin
      phase_next       = PH_BLANK;
      accumulator_next = '0;
      active_base_next = '0;
      minus_seen_next  = 1'b0;
      position_next    = '0;
    end
  end

  // Result request towards the result queue; the sign is the one seen so far
  // in this string, since a restart clears the next-state copy.
  assign res.valid           = take && emit;
  assign res.data.acc        = emit_acc;
  assign res.data.neg        = minus_seen;
  assign res.data.end_offset = ttip_pkg::END_W'(emit_pos);
  assign res.data.end_valid  = emit_valid;

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BLANK;
      accumulator <= '0;
      active_base <= '0;
      minus_seen  <= 1'b0;
      position    <= '0;
    end else if (take) begin
      phase       <= phase_next;
      accumulator <= accumulator_next;
      active_base <= active_base_next;
      minus_seen  <= minus_seen_next;
      position    <= position_next;
    end
  end

endmodule

`default_nettype wire

[design/ttip_outq.sv]
// ----------------------------------------------------------------------------
// ttip_outq
// Result queue; the head is cut to width and sign handled on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_outq (
  input  wire                 clk,
  input  wire                 rst,
  input  ttip_pkg::cfg_t      cfg,
  input  ttip_pkg::raw_link_t res,
  output logic                res_full,
  output logic                empty,
  input  wire                 pop,
  output ttip_pkg::result_t   result
);

  ttip_pkg::raw_t                      entries [ttip_pkg::Q_DEPTH];
  ttip_pkg::raw_t                      head;
  logic [ttip_pkg::Q_PTR_W-1:0]        wptr;
  logic [ttip_pkg::Q_PTR_W-1:0]        rptr;
  logic [ttip_pkg::Q_CNT_W-1:0]        count;
  logic                                rd_en;

  assign res_full = (count == ttip_pkg::Q_CNT_W'(ttip_pkg::Q_DEPTH));
  assign empty    = (count == '0);
  assign rd_en    = pop && !empty;
  assign head     = entries[rptr];

  // Format the oldest result for the ports.
  assign result.value      = ttip_pkg::finish_value(head.acc, head.neg, cfg.signed_mode,
                                                    cfg.width_select);
  assign result.end_offset = head.end_offset;
  assign result.end_valid  = head.end_valid;

  // Result storage.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      entries[wptr] <= res.data;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (res.valid) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      if (res.valid && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !res.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/text_to_integer_parser_top.sv]
// ----------------------------------------------------------------------------
// text_to_integer_parser_top
// Streaming text-to-integer parser with a queue interface on both sides.
// ----------------------------------------------------------------------------
// Text bytes are pushed one per cycle while full is low; a string ends at a
// zero byte or at a byte marked final_byte. Each string gives exactly one
// result: the parsed value (cut to the selected width, negated on a minus
// sign, sign extended in signed mode), the offset where parsing stopped and
// a flag, low for an empty string and for a blank-only or sign-only string
// ended by final_byte. The block takes one byte per cycle while the result
// queue has room; the rate is set by the parsing state machine, which does
// one multiply-by-base and add per byte. With both two-entry queues empty,
// the byte ending a number is registered in the byte queue and its result
// then in the result queue. The registers are always ready, but they should
// be written only while no string is in progress through the block, since
// signed mode and width are applied as results leave the result queue.
`default_nettype none

module text_to_integer_parser_top #(
  parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 push,
  output logic                                full,
  input  ttip_pkg::item_t                     item,
  output logic                                empty,
  input  wire                                 pop,
  output ttip_pkg::result_t                   result,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [ttip_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [ttip_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ttip_pkg::cfg_t      cfg;
  ttip_pkg::byte_link_t link;
  ttip_pkg::raw_link_t res;
  logic                take;
  logic                res_full;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix        <= ttip_pkg::RADIX_RST;
      cfg.signed_mode  <= ttip_pkg::SIGNED_RST;
      cfg.width_select <= ttip_pkg::WIDTH_SEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttip_pkg::REG_RADIX: begin
          cfg.radix <= cfg_data;
        end
        ttip_pkg::REG_SIGNED_MODE: begin
          cfg.signed_mode <= cfg_data[0];
        end
        ttip_pkg::REG_WIDTH_SEL: begin
          cfg.width_select <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ttip_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .link (link),
    .take (take)
  );

  ttip_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .link     (link),
    .take     (take),
    .res_full (res_full),
    .res      (res)
  );

  ttip_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

[tb/text_to_integer_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// text_to_integer_parser_top_tb
// Self-checking bench for the streaming text-to-integer parser.
// ----------------------------------------------------------------------------
// Text bytes go in through the push/full side and every accepted byte is run
// through a parser model kept in this bench, which queues the number each
// finished string should produce. A readout process pops results with random
// stalls and compares value, end offset and end flag against the oldest
// queued number. Directed strings cover the corner cases of blanks, signs,
// prefixes and odd bases; random phases with fresh register settings follow,
// and a closing run of blanks with no idling checks back-to-back traffic.
`default_nettype none

module text_to_integer_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttip_pkg::*;

  localparam int unsigned RANDOM_BYTES  = 1390;
  localparam int unsigned BLANK_RUN     = 30;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    SKIP_BLANKS,
    AFTER_SIGN,
    ZERO_AUTO,
    ZERO_FIXED,
    IN_DIGITS,
    DRAINING
  } scan_phase_e;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   push      = 1'b0;
  logic                   full;
  item_t                  item      = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Parser model state and its copy of the registers.
  scan_phase_e  scan_phase;
  logic [63:0]  acc_value;
  logic [4:0]   num_base;
  logic         minus_sign;
  logic [15:0]  char_pos;
  logic [4:0]   radix_reg;
  logic         signed_reg;
  logic [1:0]   wsel_reg;

  // Numbers the parser owes us, oldest first.
  result_t      awaiting_numbers[$];
  result_t      want;

  int unsigned  mismatches     = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  bytes_accepted = 0;
  int unsigned  pop_hold       = 0;
  bit           idle_en        = 1'b1;

  text_to_integer_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic void start_new_string();
    scan_phase = SKIP_BLANKS;
    acc_value  = '0;
    num_base   = '0;
    minus_sign = 1'b0;
    char_pos   = '0;
  endfunction

  // The byte position counter sticks at its top value.
  function automatic logic [15:0] bump(logic [15:0] p);
    return (p == '1) ? p : p + 16'd1;
  endfunction

  // Hex-capable digit value; 32 marks a byte that is no digit at all.
  function automatic logic [5:0] digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
    if (c >= CH_A_LOW && c <= CH_F_LOW) return 6'(c - CH_A_LOW + 8'd10);
    if (c >= CH_A_UP && c <= CH_F_UP) return 6'(c - CH_A_UP + 8'd10);
    return 6'd32;
  endfunction

  // Queue the number for the string: negate, cut to width, then extend.
  function automatic void emit_number(bit ok, logic [15:0] at);
    result_t     r;
    logic [63:0] v;
    logic [63:0] keep;
    int unsigned bits;
    bits = 8 << wsel_reg;
    v = ok ? acc_value : 64'd0;
    if (signed_reg && minus_sign) v = -v;
    if (bits < 64) begin
      keep = (64'd1 << bits) - 64'd1;
      v = v & keep;
      if (signed_reg && v[bits-1]) v = v | ~keep;
    end
    r.value      = v;
    r.end_offset = ok ? at : 16'd0;
    r.end_valid  = ok;
    awaiting_numbers.push_back(r);
  endfunction

  function automatic void take_digit(logic [7:0] c, logic last);
    logic [15:0] p;
    logic [5:0]  d;
    p = char_pos;
    if (c == CH_NUL) begin
      emit_number(1'b1, p);
      start_new_string();
      return;
    end
    d = digit_value(c);
    // A non-digit stops the number; the rest of the string is skipped.
    if (d >= {1'b0, num_base}) begin
      emit_number(1'b1, p);
      if (last) start_new_string();
      else scan_phase = DRAINING;
      return;
    end
    acc_value = acc_value * 64'(num_base) + 64'(d);
    if (last) begin
      emit_number(1'b1, bump(p));
      start_new_string();
      return;
    end
    scan_phase = IN_DIGITS;
    char_pos   = bump(p);
  endfunction

  // First byte after blanks and sign fixes the base.
  function automatic void take_first(logic [7:0] c, logic last);
    if (radix_reg == 5'd0) num_base = (c == CH_ZERO) ? 5'd8 : 5'd10;
    else num_base = radix_reg;
    if (c == CH_ZERO && !last) begin
      scan_phase = (radix_reg == 5'd0) ? ZERO_AUTO : ZERO_FIXED;
      char_pos   = bump(char_pos);
    end else begin
      take_digit(c, last);
    end
  endfunction

  // Byte after a leading zero: an x or b prefix letter, or an ordinary digit.
  function automatic void take_prefix(logic [7:0] c, logic last, bit allow_x, bit allow_b);
    logic [7:0] lower;
    lower = c | CASE_BIT;
    if (!last && lower == CH_X_LOW && allow_x) begin
      num_base = 5'd16;
    end else if (!last && lower == CH_B_LOW && allow_b) begin
      num_base = 5'd2;
    end else begin
      take_digit(c, last);
      return;
    end
    scan_phase = IN_DIGITS;
    char_pos   = bump(char_pos);
  endfunction

  function automatic void parse_char(item_t req);
    logic [7:0] c;
    logic       last;
    c    = req.char_in;
    last = req.final_byte;
    case (scan_phase)
      SKIP_BLANKS: begin
        if (char_pos == 16'd0 && c == CH_NUL) begin
          emit_number(1'b0, 16'd0);
          start_new_string();
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          if (last) begin
            emit_number(1'b0, 16'd0);
            start_new_string();
          end else begin
            char_pos = bump(char_pos);
          end
        end else if (signed_reg && (c == CH_MINUS || c == CH_PLUS)) begin
          minus_sign = (c == CH_MINUS);
          if (last) begin
            emit_number(1'b0, 16'd0);
            start_new_string();
          end else begin
            scan_phase = AFTER_SIGN;
            char_pos   = bump(char_pos);
          end
        end else begin
          take_first(c, last);
        end
      end
      AFTER_SIGN: take_first(c, last);
      ZERO_AUTO:  take_prefix(c, last, 1'b1, 1'b1);
      ZERO_FIXED: take_prefix(c, last, num_base == 5'd16, num_base == 5'd2);
      IN_DIGITS:  take_digit(c, last);
      default: begin
        if (c == CH_NUL || last) start_new_string();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] any_case(logic [7:0] c);
    return ($urandom_range(0, 1) != 0) ? (c & ~CASE_BIT) : c;
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    return (d < 10) ? 8'(CH_ZERO + d) : any_case(8'(CH_A_LOW + d - 10));
  endfunction

  // Push one byte, with an occasional gap first, and feed it to the model.
  task automatic send_byte(input logic [7:0] c, input logic last);
    item_t req;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.char_in    = c;
    req.final_byte = last;
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    parse_char(req);
    bytes_accepted++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(8'(s[i]), fin && (i == s.len() - 1));
    end
  endtask

  // Stop pushing and let every owed number drain out of the block.
  task automatic wait_idle();
    push <= 1'b0;
    while (awaiting_numbers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RADIX:       radix_reg  = data;
      REG_SIGNED_MODE: signed_reg = data[0];
      REG_WIDTH_SEL:   wsel_reg   = data[1:0];
      default: ;
    endcase
  endtask

  // New register set, written only once the block has gone quiet.
  task automatic set_config(input logic [4:0] rdx, input logic sgn, input logic [1:0] wsel,
                            input bit stray_write);
    wait_idle();
    if (stray_write) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 31)));
    cfg_write(REG_RADIX, rdx);
    cfg_write(REG_SIGNED_MODE, {4'($urandom_range(0, 15)), sgn});
    cfg_write(REG_WIDTH_SEL, {3'($urandom_range(0, 7)), wsel});
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed numbers for the current base, some raw noise.
  task automatic send_random_string();
    logic [7:0]  text[$];
    int unsigned eff;
    int unsigned pick;
    bit          noise;
    bit          end_nul;
    noise = ($urandom_range(0, 6) == 0);
    if (noise) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        text.push_back(($urandom_range(0, 2) == 0) ? 8'(CH_TAB + $urandom_range(0, 4)) : CH_SPACE);
      end
      pick = $urandom_range(0, 3);
      if (pick == 0) text.push_back(CH_MINUS);
      else if (pick == 1) text.push_back(CH_PLUS);
      eff  = (radix_reg > 5'd16) ? 16 : radix_reg;
      pick = $urandom_range(0, 3);
      if (radix_reg == 5'd0) begin
        eff = 10;
        if (pick == 0) begin
          text.push_back(CH_ZERO);
          text.push_back(any_case(CH_X_LOW));
          eff = 16;
        end else if (pick == 1) begin
          text.push_back(CH_ZERO);
          text.push_back(any_case(CH_B_LOW));
          eff = 2;
        end else if (pick == 2) begin
          text.push_back(CH_ZERO);
          eff = 8;
        end
      end else if (pick == 0 && radix_reg == 5'd16) begin
        text.push_back(CH_ZERO);
        text.push_back(any_case(CH_X_LOW));
      end else if (pick == 0 && radix_reg == 5'd2) begin
        text.push_back(CH_ZERO);
        text.push_back(any_case(CH_B_LOW));
      end
      repeat ($urandom_range(1, 22)) text.push_back(digit_char($urandom_range(0, eff - 1)));
      // Sometimes a stray byte that may stop the number, with up to three digits after it.
      if ($urandom_range(0, 7) == 0) begin
        text.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) text.push_back(digit_char($urandom_range(0, eff - 1)));
      end
    end
    end_nul = !noise && ($urandom_range(0, 3) == 0);
    if (end_nul) text.push_back(CH_NUL);
    foreach (text[i]) begin
      if (i == text.size() - 1) send_byte(text[i], end_nul ? 1'($urandom_range(0, 1)) : 1'b1);
      else send_byte(text[i], noise && $urandom_range(0, 7) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at their reset values: signed, base 10, 64 bits.
  task automatic test_reset_config();
    send_text("-5", 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_text(" ", 1'b1);
    send_text("+", 1'b1);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_text("4z1", 1'b1);
  endtask

  // Base taken from the prefix, including a prefix with nothing after it.
  task automatic test_auto_radix();
    set_config(5'd0, 1'b1, WSEL_16, 1'b0);
    send_text("0x", 1'b1);
    send_text("0", 1'b1);
    send_text("-0X1f", 1'b1);
  endtask

  // Base 1, bases above 16, and the extreme byte codes at 8 bits.
  task automatic test_odd_radix();
    set_config(5'd1, 1'b0, WSEL_8, 1'b0);
    send_text("01", 1'b1);
    set_config(5'd17, 1'b0, WSEL_32, 1'b0);
    send_text("fg", 1'b1);
    set_config(5'd31, 1'b1, WSEL_8, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
  endtask

  // Random phases, each under a fresh register set.
  task automatic test_random_strings();
    int unsigned stop_at;
    int unsigned phase_end;
    logic [4:0]  rdx;
    stop_at = bytes_accepted + RANDOM_BYTES;
    while (bytes_accepted < stop_at) begin
      case ($urandom_range(0, 7))
        0, 1:    rdx = 5'd0;
        2:       rdx = 5'd16;
        3:       rdx = 5'd10;
        4:       rdx = 5'd2;
        5:       rdx = 5'd8;
        6:       rdx = 5'd31;
        default: rdx = 5'($urandom_range(0, 31));
      endcase
      set_config(rdx, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 $urandom_range(0, 3) == 0);
      idle_en   = ($urandom_range(0, 3) != 0);
      phase_end = bytes_accepted + $urandom_range(60, 140);
      while (bytes_accepted < phase_end && bytes_accepted < stop_at) send_random_string();
    end
  endtask

  // A run of blanks and then a digit, back to back with no idling.
  task automatic test_blank_run();
    set_config(5'd10, 1'b1, WSEL_64, 1'b0);
    idle_en = 1'b0;
    repeat (BLANK_RUN) send_byte(CH_SPACE, 1'b0);
    send_text("7", 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result readout and comparison, with random pop stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_hold = 0;
    end else begin
      if (pop && !empty) begin
        if (awaiting_numbers.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: value %h offset %0d valid %b",
                   $time, result.value, result.end_offset, result.end_valid);
        end else begin
          want = awaiting_numbers.pop_front();
          if (result.value !== want.value) begin
            mismatches++;
            $display("%0t: value expected %h actual %h", $time, want.value, result.value);
          end
          if (result.end_offset !== want.end_offset) begin
            mismatches++;
            $display("%0t: end_offset expected %0d actual %0d", $time,
                     want.end_offset, result.end_offset);
          end
          if (result.end_valid !== want.end_valid) begin
            mismatches++;
            $display("%0t: end_valid expected %b actual %b", $time,
                     want.end_valid, result.end_valid);
          end
        end
      end
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        pop_hold = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    radix_reg  = RADIX_RST;
    signed_reg = SIGNED_RST;
    wsel_reg   = WIDTH_SEL_RST;
    start_new_string();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_auto_radix();
    test_odd_radix();
    test_random_strings();
    test_blank_run();
    wait_idle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
